>>> rtl/core/evenodd_parity_encoder_assert.svh
// assertion macros for the evenodd parity encoder checks
`ifndef EVENODD_PARITY_ENCODER_ASSERT_SVH
`define EVENODD_PARITY_ENCODER_ASSERT_SVH

// condition holds in the same cycle
`define EPE_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("evenodd encoder check failed");

// condition holds in the next cycle
`define EPE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("evenodd encoder check failed");

`endif

>>> rtl/core/epe_pkg.sv
// shared types and constants for the evenodd parity encoder
`timescale 1ns / 1ps
package epe_pkg;

    localparam int MAX_COLUMNS_DEF = 17;
    localparam int WPS_DEF         = 64;

    localparam int FUNC_W  = 2;
    localparam int INDEX_W = 5;
    localparam int WPOS_W  = 6;
    localparam int WORD_W  = 64;

    localparam logic [INDEX_W-1:0] K_RESET = 5'd5;
    localparam logic [INDEX_W-1:0] K_MIN   = 5'd3;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_ABSORB    = 2'd0,
        FUNC_READ_ROW  = 2'd1,
        FUNC_READ_DIAG = 2'd2,
        FUNC_CLEAR     = 2'd3
    } func_t;

    typedef struct packed {
        logic capture;
        logic execute;
        logic clear;
    } epe_cmd_t;

    typedef struct packed {
        logic out_free;
        logic clear_last;
        logic is_clear;
    } epe_sts_t;

endpackage

>>> rtl/core/evenodd_parity_encoder.sv
// evenodd parity encoder: row and diagonal parity over one stripe
// an input beat is captured into the item registers, its result registered once the
// output is free; no new beat is taken before that: the item reads the parity memories
// at capture and writes them back with its result; a clear item then runs a zeroing sweep
// of the parity stores; reset: all control cleared, k = 5, then the same sweep runs
// before the first input beat is taken; config writes are taken at any time
`timescale 1ns / 1ps
module evenodd_parity_encoder
    import epe_pkg::*;
#(
    parameter int MAX_COLUMNS      = MAX_COLUMNS_DEF,
    parameter int WORDS_PER_SYMBOL = WPS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [INDEX_W-1:0]  data_columns,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [FUNC_W-1:0]   func,
    input  logic [INDEX_W-1:0]  column,
    input  logic [INDEX_W-1:0]  row,
    input  logic [WPOS_W-1:0]   word_pos,
    input  logic [WORD_W-1:0]   data_word,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [WORD_W-1:0]   parity_word,
    output logic                status
);

    epe_cmd_t cmd;
    epe_sts_t sts;

    assign cfg_ready = 1'b1;

    epe_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    epe_datapath #(
        .MAX_COLUMNS      (MAX_COLUMNS),
        .WORDS_PER_SYMBOL (WORDS_PER_SYMBOL)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .cfg_valid    (cfg_valid && cfg_ready),
        .data_columns (data_columns),
        .func         (func),
        .column       (column),
        .row          (row),
        .word_pos     (word_pos),
        .data_word    (data_word),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .parity_word  (parity_word),
        .status       (status)
    );

endmodule

>>> rtl/core/epe_datapath.sv
// parity stores, item registers, config register and result register
`timescale 1ns / 1ps
module epe_datapath
    import epe_pkg::*;
#(
    parameter int MAX_COLUMNS      = MAX_COLUMNS_DEF,
    parameter int WORDS_PER_SYMBOL = WPS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  epe_cmd_t            cmd,
    output epe_sts_t            sts,
    input  logic                cfg_valid,
    input  logic [INDEX_W-1:0]  data_columns,
    input  logic [FUNC_W-1:0]   func,
    input  logic [INDEX_W-1:0]  column,
    input  logic [INDEX_W-1:0]  row,
    input  logic [WPOS_W-1:0]   word_pos,
    input  logic [WORD_W-1:0]   data_word,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [WORD_W-1:0]   parity_word,
    output logic                status
);

    localparam int ROW_DEPTH  = MAX_COLUMNS * WORDS_PER_SYMBOL;
    localparam int DIAG_DEPTH = (MAX_COLUMNS - 1) * WORDS_PER_SYMBOL;
    localparam int ROW_AW     = $clog2(ROW_DEPTH);
    localparam int DIAG_AW    = $clog2(DIAG_DEPTH);
    localparam int ADJ_AW     = (WORDS_PER_SYMBOL > 1) ? $clog2(WORDS_PER_SYMBOL) : 1;

    logic [WORD_W-1:0] row_mem  [ROW_DEPTH];
    logic [WORD_W-1:0] diag_mem [DIAG_DEPTH];
    logic [WORD_W-1:0] adj_mem  [WORDS_PER_SYMBOL];

    logic [INDEX_W-1:0] k_reg;
    logic [ROW_AW-1:0]  clr_cnt_reg;

    func_t              func_reg;
    logic               err_reg;
    logic               row_lt_reg;
    logic               to_adj_reg;
    logic [WORD_W-1:0]  data_reg;
    logic [ROW_AW-1:0]  row_addr_reg;
    logic [DIAG_AW-1:0] diag_addr_reg;
    logic [ADJ_AW-1:0]  adj_addr_reg;

    logic [WORD_W-1:0]  row_rd_reg;
    logic [WORD_W-1:0]  diag_rd_reg;
    logic [WORD_W-1:0]  adj_rd_reg;

    logic               out_valid_reg;
    logic [WORD_W-1:0]  parity_word_reg;
    logic               status_reg;

    func_t              in_func;
    logic               row_bad;
    logic               wp_bad;
    logic               col_bad;
    logic               err_in;
    logic [INDEX_W-1:0] k_m1;
    logic [INDEX_W:0]   diag_sum;
    logic [INDEX_W-1:0] diag_idx;
    logic [INDEX_W-1:0] diag_sel;
    logic [ROW_AW-1:0]  row_addr_in;
    logic [DIAG_AW-1:0] diag_addr_in;
    logic [ADJ_AW-1:0]  adj_addr_in;

    logic               do_absorb;
    logic               row_we;
    logic               diag_we;
    logic               adj_we;
    logic [ROW_AW-1:0]  row_wa;
    logic [DIAG_AW-1:0] diag_wa;
    logic [ADJ_AW-1:0]  adj_wa;
    logic [WORD_W-1:0]  row_wd;
    logic [WORD_W-1:0]  diag_wd;
    logic [WORD_W-1:0]  adj_wd;
    logic [WORD_W-1:0]  result_word;

    // decode of the incoming beat
    always_comb
    begin
        in_func      = func_t'(func);
        row_bad      = row >= k_reg;
        wp_bad       = 32'(word_pos) >= WORDS_PER_SYMBOL;
        col_bad      = column >= k_reg;
        err_in       = (in_func != FUNC_CLEAR) &&
                       (row_bad || wp_bad || ((in_func == FUNC_ABSORB) && col_bad));
        k_m1         = k_reg - 5'd1;
        diag_sum     = {1'b0, column} + {1'b0, row};
        diag_idx     = (diag_sum >= {1'b0, k_reg}) ? INDEX_W'(diag_sum - {1'b0, k_reg})
                                                   : INDEX_W'(diag_sum);
        diag_sel     = (in_func == FUNC_ABSORB) ? diag_idx : row;
        row_addr_in  = ROW_AW'(32'(row) * WORDS_PER_SYMBOL + 32'(word_pos));
        diag_addr_in = DIAG_AW'(32'(diag_sel) * WORDS_PER_SYMBOL + 32'(word_pos));
        adj_addr_in  = ADJ_AW'(word_pos);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg <= K_RESET;
        end
        else if (cfg_valid)
        begin
            if (data_columns < K_MIN)
            begin
                k_reg <= K_MIN;
            end
            else if (32'(data_columns) > MAX_COLUMNS)
            begin
                k_reg <= INDEX_W'(MAX_COLUMNS);
            end
            else
            begin
                k_reg <= data_columns;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else if (cmd.clear)
        begin
            clr_cnt_reg <= sts.clear_last ? '0 : clr_cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            func_reg      <= in_func;
            err_reg       <= err_in;
            row_lt_reg    <= row < k_m1;
            to_adj_reg    <= diag_idx == k_m1;
            data_reg      <= data_word;
            row_addr_reg  <= row_addr_in;
            diag_addr_reg <= diag_addr_in;
            adj_addr_reg  <= adj_addr_in;
        end
    end

    // write side: clearing sweep or read-modify-write of an absorbed word
    always_comb
    begin
        do_absorb = cmd.execute && (func_reg == FUNC_ABSORB) && !err_reg;
        if (cmd.clear)
        begin
            row_we  = 1'b1;
            diag_we = 32'(clr_cnt_reg) < DIAG_DEPTH;
            adj_we  = 32'(clr_cnt_reg) < WORDS_PER_SYMBOL;
            row_wa  = clr_cnt_reg;
            diag_wa = clr_cnt_reg[DIAG_AW-1:0];
            adj_wa  = clr_cnt_reg[ADJ_AW-1:0];
            row_wd  = '0;
            diag_wd = '0;
            adj_wd  = '0;
        end
        else
        begin
            row_we  = do_absorb;
            diag_we = do_absorb && row_lt_reg && !to_adj_reg;
            adj_we  = do_absorb && row_lt_reg && to_adj_reg;
            row_wa  = row_addr_reg;
            diag_wa = diag_addr_reg;
            adj_wa  = adj_addr_reg;
            row_wd  = row_rd_reg ^ data_reg;
            diag_wd = diag_rd_reg ^ data_reg;
            adj_wd  = adj_rd_reg ^ data_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (row_we)
        begin
            row_mem[row_wa] <= row_wd;
        end
        if (cmd.capture)
        begin
            row_rd_reg <= row_mem[row_addr_in];
        end
    end

    always_ff @(posedge clk)
    begin
        if (diag_we)
        begin
            diag_mem[diag_wa] <= diag_wd;
        end
        if (cmd.capture)
        begin
            diag_rd_reg <= diag_mem[diag_addr_in];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adj_we)
        begin
            adj_mem[adj_wa] <= adj_wd;
        end
        if (cmd.capture)
        begin
            adj_rd_reg <= adj_mem[adj_addr_in];
        end
    end

    always_comb
    begin
        unique case (func_reg)
            FUNC_READ_ROW:  result_word = row_rd_reg;
            FUNC_READ_DIAG: result_word = row_lt_reg ? (diag_rd_reg ^ adj_rd_reg) : '0;
            default:        result_word = '0;
        endcase
        if (err_reg)
        begin
            result_word = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.execute)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.execute)
        begin
            parity_word_reg <= result_word;
            status_reg      <= err_reg;
        end
    end

    assign sts.out_free   = !out_valid_reg || !out_stall;
    assign sts.clear_last = clr_cnt_reg == ROW_AW'(ROW_DEPTH - 1);
    assign sts.is_clear   = func_reg == FUNC_CLEAR;

    assign out_valid   = out_valid_reg;
    assign parity_word = parity_word_reg;
    assign status      = status_reg;

endmodule

>>> rtl/core/epe_ctrl.sv
// control state machine for the evenodd parity encoder
`timescale 1ns / 1ps
module epe_ctrl
    import epe_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    input  epe_sts_t sts,
    output epe_cmd_t cmd
);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC
    } state_t;

    state_t state_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            unique case (state_reg)
                S_CLEAR:
                begin
                    if (sts.clear_last)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        state_reg <= S_EXEC;
                    end
                end
                S_EXEC:
                begin
                    if (sts.out_free)
                    begin
                        state_reg <= sts.is_clear ? S_CLEAR : S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign in_stall    = state_reg != S_IDLE;
    assign cmd.capture = (state_reg == S_IDLE) && in_valid;
    assign cmd.execute = (state_reg == S_EXEC) && sts.out_free;
    assign cmd.clear   = state_reg == S_CLEAR;

endmodule

>>> rtl/core/epe_checker.sv
// port-level checks for the evenodd parity encoder
`timescale 1ns / 1ps
`include "evenodd_parity_encoder_assert.svh"
module epe_checker
    import epe_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input logic               out_valid,
    input logic               out_stall,
    input logic [WORD_W-1:0]  parity_word,
    input logic               status
);

    `EPE_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)
    `EPE_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(parity_word) && $stable(status))
    `EPE_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)
    `EPE_ASSERT_SAME(a_err_zero_word, out_valid && status, parity_word == '0)

endmodule

bind evenodd_parity_encoder epe_checker u_checker (.*);

>>> sim/evenodd_parity_encoder_tb.sv
// testbench for the evenodd parity encoder: directed and random beats checked against a predictor
`timescale 1ns / 1ps
module evenodd_parity_encoder_tb;
    import epe_pkg::*;

    localparam int NCOL           = MAX_COLUMNS_DEF;
    localparam int WPS            = WPS_DEF;
    localparam int WATCHDOG_LIMIT = 8000;
    localparam int TAIL_CYCLES    = 12;

    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic              st;
    } parity_res_t;

    logic                clk;
    logic                rst_n;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [INDEX_W-1:0]  data_columns;
    logic                in_valid;
    logic                in_stall;
    logic [FUNC_W-1:0]   func;
    logic [INDEX_W-1:0]  column;
    logic [INDEX_W-1:0]  row;
    logic [WPOS_W-1:0]   word_pos;
    logic [WORD_W-1:0]   data_word;
    logic                out_valid;
    logic                out_stall;
    logic [WORD_W-1:0]   parity_word;
    logic                status;

    // predictor state
    logic [WORD_W-1:0] row_acc  [NCOL*WPS];
    logic [WORD_W-1:0] diag_acc [(NCOL-1)*WPS];
    logic [WORD_W-1:0] s_adjust [WPS];
    int                stripe_k;

    parity_res_t parity_due_q[$];
    int          errors;
    int          n_items;
    int          n_results;
    int          n_cfg;
    int          n_clear;
    int          idle_cycles;
    bit          quiet;

    evenodd_parity_encoder dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .data_columns (data_columns),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .func         (func),
        .column       (column),
        .row          (row),
        .word_pos     (word_pos),
        .data_word    (data_word),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .parity_word  (parity_word),
        .status       (status)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic void wipe_stripe();
        foreach (row_acc[i]) row_acc[i] = '0;
        foreach (diag_acc[i]) diag_acc[i] = '0;
        foreach (s_adjust[i]) s_adjust[i] = '0;
    endfunction

    function automatic parity_res_t evenodd_predict(input func_t f, input int c, input int r,
                                                    input int w, input logic [WORD_W-1:0] d);
        parity_res_t res;
        int          dg;
        res = '0;
        if (f == FUNC_CLEAR)
        begin
            wipe_stripe();
        end
        else if (r >= stripe_k || w >= WPS || (f == FUNC_ABSORB && c >= stripe_k))
        begin
            res.st = 1'b1;
        end
        else if (f == FUNC_ABSORB)
        begin
            row_acc[r*WPS + w] ^= d;
            if (r < stripe_k - 1)
            begin
                dg = c + r;
                if (dg >= stripe_k)
                    dg -= stripe_k;
                if (dg == stripe_k - 1)
                    s_adjust[w] ^= d;
                else
                    diag_acc[dg*WPS + w] ^= d;
            end
        end
        else if (f == FUNC_READ_ROW)
        begin
            res.word = row_acc[r*WPS + w];
        end
        else if (r < stripe_k - 1)
        begin
            res.word = diag_acc[r*WPS + w] ^ s_adjust[w];
        end
        return res;
    endfunction

    // called and returns just after a falling edge
    task automatic drive_item(input func_t f, input logic [INDEX_W-1:0] c,
                              input logic [INDEX_W-1:0] r, input logic [WPOS_W-1:0] w,
                              input logic [WORD_W-1:0] d);
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge clk);
        end
        in_valid  = 1'b1;
        func      = f;
        column    = c;
        row       = r;
        word_pos  = w;
        data_word = d;
        do
            @(posedge clk);
        while (in_stall);
        parity_due_q.insert(parity_due_q.size(),
                            evenodd_predict(f, int'(c), int'(r), int'(w), d));
        n_items++;
        if (f == FUNC_CLEAR)
            n_clear++;
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    task automatic drain();
        while (parity_due_q.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_columns(input logic [INDEX_W-1:0] v);
        drain();
        cfg_valid    = 1'b1;
        data_columns = v;
        do
            @(posedge clk);
        while (!cfg_ready);
        stripe_k = (v < K_MIN) ? K_MIN : ((v > NCOL) ? NCOL : v);
        n_cfg++;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    function automatic logic [WORD_W-1:0] rand_word();
        return {$urandom(), $urandom()};
    endfunction

    task automatic random_item();
        int                  pick;
        logic [INDEX_W-1:0]  c;
        logic [INDEX_W-1:0]  r;
        logic [WPOS_W-1:0]   w;
        pick = $urandom_range(0, 99);
        c    = INDEX_W'($urandom_range(0, stripe_k - 1));
        r    = INDEX_W'($urandom_range(0, stripe_k - 1));
        // mostly a few word positions so that parity words build up
        w    = ($urandom_range(0, 3) == 0) ? WPOS_W'($urandom_range(0, WPS - 1))
                                           : WPOS_W'($urandom_range(0, 3));
        if (pick < 55)
            drive_item(FUNC_ABSORB, c, r, w, rand_word());
        else if (pick < 70)
            drive_item(FUNC_READ_ROW, c, r, w, rand_word());
        else if (pick < 85)
            drive_item(FUNC_READ_DIAG, c, r, w, rand_word());
        else if (pick < 98)
            drive_item(func_t'($urandom_range(0, 2)), INDEX_W'($urandom_range(0, 31)),
                       INDEX_W'($urandom_range(0, 31)), WPOS_W'($urandom_range(0, WPS - 1)),
                       rand_word());
        else
            drive_item(FUNC_CLEAR, INDEX_W'($urandom_range(0, 31)),
                       INDEX_W'($urandom_range(0, 31)), WPOS_W'($urandom_range(0, WPS - 1)),
                       rand_word());
    endtask

    task automatic test_directed();
        drive_item(FUNC_READ_ROW, 5'd0, 5'd0, 6'd0, '1);
        drive_item(FUNC_ABSORB, 5'd0, 5'd0, 6'd0, '1);
        drive_item(FUNC_ABSORB, 5'd4, 5'd3, 6'd63, '0);
        drive_item(FUNC_ABSORB, 5'd1, 5'd3, 6'd63, 64'hA5A5_5A5A_F00F_0FF0);
        drive_item(FUNC_ABSORB, 5'd4, 5'd4, 6'd0, 64'h8000_0000_0000_0001);
        drive_item(FUNC_ABSORB, 5'd2, 5'd1, 6'd63, rand_word());
        drive_item(FUNC_ABSORB, 5'd3, 5'd2, 6'd63, rand_word());
        drive_item(FUNC_READ_ROW, 5'd0, 5'd0, 6'd0, '0);
        drive_item(FUNC_READ_ROW, 5'd0, 5'd4, 6'd0, '0);
        drive_item(FUNC_READ_ROW, 5'd0, 5'd3, 6'd63, '0);
        drive_item(FUNC_READ_DIAG, 5'd0, 5'd0, 6'd0, '0);
        drive_item(FUNC_READ_DIAG, 5'd0, 5'd3, 6'd63, '0);
        drive_item(FUNC_READ_DIAG, 5'd0, 5'd0, 6'd63, '0);
        // diagonal row k-1 reads as zero
        drive_item(FUNC_READ_DIAG, 5'd0, 5'd4, 6'd63, '0);
        // out of range indices
        drive_item(FUNC_ABSORB, 5'd5, 5'd0, 6'd0, '1);
        drive_item(FUNC_ABSORB, 5'd31, 5'd1, 6'd1, '1);
        drive_item(FUNC_ABSORB, 5'd0, 5'd5, 6'd0, '1);
        drive_item(FUNC_READ_ROW, 5'd31, 5'd31, 6'd63, '0);
        drive_item(FUNC_READ_DIAG, 5'd0, 5'd5, 6'd0, '0);
        drive_item(FUNC_READ_ROW, 5'd31, 5'd3, 6'd63, '0);
        // clear ignores its index fields
        drive_item(FUNC_CLEAR, 5'd31, 5'd31, 6'd63, '1);
        drive_item(FUNC_READ_ROW, 5'd0, 5'd0, 6'd0, '0);
        drive_item(FUNC_READ_DIAG, 5'd0, 5'd3, 6'd63, '0);
    endtask

    task automatic test_column_settings();
        logic [INDEX_W-1:0] settings[9];
        settings = '{5'd0, 5'd31, 5'd17, 5'd2, 5'd7, 5'd18, 5'd3, 5'd13, 5'd5};
        foreach (settings[i])
        begin
            write_columns(settings[i]);
            repeat (40) random_item();
        end
    endtask

    task automatic test_drain_pause();
        int                 i;
        logic [WPOS_W-1:0]  w;
        w = WPOS_W'($urandom_range(0, WPS - 1));
        for (i = 0; i < 12; i++)
            drive_item(FUNC_ABSORB, INDEX_W'($urandom_range(0, stripe_k - 1)),
                       INDEX_W'($urandom_range(0, stripe_k - 1)), w, rand_word());
        drain();
        for (i = 0; i < stripe_k; i++)
        begin
            drive_item(FUNC_READ_ROW, 5'd0, INDEX_W'(i), w, '0);
            drive_item(FUNC_READ_DIAG, 5'd0, INDEX_W'(i), w, '0);
        end
    endtask

    task automatic test_calm_tail();
        quiet = 1'b1;
        write_columns(5'd11);
        repeat (70) random_item();
    endtask

    // receiver side stall bursts
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!quiet && $urandom_range(0, 7) == 0)
            begin
                out_stall = 1'b1;
                repeat ($urandom_range(1, 15)) @(negedge clk);
                out_stall = 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin : result_check
        parity_res_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            n_results++;
            if (parity_due_q.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result beat, expected none, actual word %h status %0d",
                         $time, parity_word, status);
            end
            else
            begin
                want = parity_due_q.pop_front();
                if (parity_word !== want.word)
                begin
                    errors++;
                    $display("%0t: parity_word mismatch, expected %h actual %h",
                             $time, want.word, parity_word);
                end
                if (status !== want.st)
                begin
                    errors++;
                    $display("%0t: status mismatch, expected %0d actual %0d",
                             $time, want.st, status);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
            (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no beat for %0d cycles, %0d results outstanding",
                     $time, idle_cycles, parity_due_q.size());
            $display("evenodd_parity_encoder verification failed");
            $finish;
        end
    end

    initial
    begin
        rst_n        = 1'b0;
        cfg_valid    = 1'b0;
        data_columns = K_RESET;
        in_valid     = 1'b0;
        func         = FUNC_ABSORB;
        column       = '0;
        row          = '0;
        word_pos     = '0;
        data_word    = '0;
        quiet        = 1'b0;
        errors       = 0;
        n_items      = 0;
        n_results    = 0;
        n_cfg        = 0;
        n_clear      = 0;
        stripe_k     = K_RESET;
        wipe_stripe();
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_column_settings();
        test_drain_pause();
        test_calm_tail();

        drain();
        repeat (TAIL_CYCLES) @(negedge clk);
        $display("%0d beats in, %0d results checked, %0d clears", n_items, n_results, n_clear);
        $display("%0d column count writes, clamped extremes and idle bursts on both sides", n_cfg);
        if (errors == 0 && parity_due_q.size() == 0)
            $display("evenodd_parity_encoder verification clean");
        else
            $display("evenodd_parity_encoder verification failed");
        $finish;
    end

endmodule

>>> files.f
+incdir+rtl/core
rtl/core/epe_pkg.sv
rtl/core/epe_datapath.sv
rtl/core/epe_ctrl.sv
rtl/core/evenodd_parity_encoder.sv
rtl/core/epe_checker.sv
sim/evenodd_parity_encoder_tb.sv
